// ===== src/lrmg_pkg.sv =====
// Package for the linear resampler with mixer gain.
// Holds shared types, register indexes and arithmetic constants.
// No dependencies.
`default_nettype none

package lrmg_pkg;

  // Sample and phase widths.
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 21;
  localparam int STEP_W   = 20;
  localparam int GAIN_W   = 9;
  localparam int LEVEL_W  = 4;
  localparam int PROD_W   = 2 * LEVEL_W;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MASTER_VOLUME = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_VOLUME = 2'd2;

  // Phase and step limits with 16 fraction bits (phase 5.16, step 4.16).
  localparam logic [PHASE_W-1:0] PHASE_ONE  = 21'h10000;
  localparam logic [STEP_W-1:0]  STEP_MIN   = 20'd1024;
  localparam logic [STEP_W-1:0]  STEP_RESET = 20'd65536;

  // Mixer volume defaults and gain reciprocal. A gain of p*256/225 is
  // estimated as (p*GAIN_RECIP) >> GAIN_SHIFT and then corrected by one.
  localparam logic [7:0]         VOLUME_RESET  = 8'd204;
  localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL = 4'd12;
  localparam int GAIN_DIV   = 225;
  localparam int GAIN_RECIP = 1165;
  localparam int GAIN_SHIFT = 10;
  localparam int GAIN_RESET = 12 * 12 * 256 / GAIN_DIV;
  localparam int LEVEL_PROD_RESET = 12 * 12;

  // Output clamp limits.
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Kind of an input item, decided by the front.
  typedef enum logic [1:0] {
    KIND_FIRST  = 2'd0,
    KIND_SECOND = 2'd1,
    KIND_LATER  = 2'd2
  } kind_t;

  // One queued item.
  typedef struct packed {
    kind_t                kind;
    logic [SAMPLE_W-1:0]  sample;
  } entry_t;

  // Derived configuration seen by the back.
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  // Mixer level of a volume byte: upper nibble, zero byte means default.
  function automatic logic [LEVEL_W-1:0] level_of(input logic [7:0] vol);
    logic [LEVEL_W-1:0] lvl;
    lvl = (vol == 8'd0) ? DEFAULT_LEVEL : vol[7:4];
    return lvl;
  endfunction

endpackage

`default_nettype wire

// ===== src/linear_resampler_with_mixer_gain.sv =====
// Top level of the linear resampler with mixer gain.
// Depends on lrmg_pkg, lrmg_front, lrmg_back and lrmg_cfg.
//
//   Channel   Direction  Carries
//   in_*      slave      one signed 16-bit source sample per item
//   out_*     master     one mixed output sample per item, tlast on the last of a run
//   cfg_*     slave      APB-style writes and reads of phase_step and the volumes
//
// The back part accepts an item, then issues one output per cycle while the output
// is not stalled. An item produces 1 to 64 outputs, or none, and the back part takes
// no new item until it has issued the last output of the current one.
// Outputs pass from issue through the multiply pipeline registers to the output.
// The queue in front lets the input side keep accepting while the output stalls.
// Reset is synchronous and active low; it clears priming, phase and the queue.
// Derived step and gain follow a register write through their own registers.
`default_nettype none

module linear_resampler_with_mixer_gain #(
  parameter int QUEUE_DEPTH = lrmg_pkg::QUEUE_DEPTH
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // Input channel.
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [15:0]                        in_tdata,   // [15:0] source_sample
  // Result channel.
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] mixed_sample
  output logic                               out_tlast,
  // Configuration port.
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire  [lrmg_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire  [lrmg_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [lrmg_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  lrmg_pkg::cfg_t   cfg;
  lrmg_pkg::entry_t q_data;
  logic             q_valid, q_ready;

  lrmg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lrmg_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data)
  );

  lrmg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

// ===== src/lrmg_queue.sv =====
// Short first-in first-out queue of classified items between front and back.
// Uses lrmg_pkg for the entry type.
`default_nettype none

module lrmg_queue #(
  parameter int DEPTH = lrmg_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  lrmg_pkg::entry_t     push_data,
  output logic                 not_full,
  output logic                 not_empty,
  input  wire                  pop,
  output lrmg_pkg::entry_t     pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lrmg_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign not_full  = (count_r != CNT_FULL);
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue fill count above depth");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill count did not grow on push");

endmodule

`default_nettype wire

// ===== src/lrmg_front.sv =====
// Front part: accepts source samples, tags each with its priming kind and
// queues it for the back part. Uses lrmg_pkg and lrmg_queue.
`default_nettype none

module lrmg_front #(
  parameter int QUEUE_DEPTH = lrmg_pkg::QUEUE_DEPTH
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [lrmg_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                             q_valid,
  input  wire                              q_ready,
  output lrmg_pkg::entry_t                 q_data
);

  // Priming count: 0 empty, 1 one sample held, 2 primed.
  logic [1:0]       prime_r, prime_nxt;
  logic             accept;
  lrmg_pkg::entry_t entry;

  assign accept = in_valid && in_ready;

  // Classify the item by how far priming has gone.
  always_comb begin
    entry.sample = in_sample;
    prime_nxt    = prime_r;
    unique case (prime_r)
      2'd0:    entry.kind = lrmg_pkg::KIND_FIRST;
      2'd1:    entry.kind = lrmg_pkg::KIND_SECOND;
      default: entry.kind = lrmg_pkg::KIND_LATER;
    endcase
    if (accept && prime_r != 2'd2) begin
      prime_nxt = prime_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= '0;
    end else begin
      prime_r <= prime_nxt;
    end
  end

  lrmg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (entry),
    .not_full  (in_ready),
    .not_empty (q_valid),
    .pop       (q_ready),
    .pop_data  (q_data)
  );

endmodule

`default_nettype wire

// ===== src/lrmg_back.sv =====
// Back part: takes classified items from the queue, keeps the sample pair
// and phase, and issues one interpolated, gain-scaled output per cycle when
// the output is not stalled, through a three-stage pipeline. Uses lrmg_pkg.
`default_nettype none

module lrmg_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  lrmg_pkg::cfg_t                   cfg,
  input  wire                              q_valid,
  output logic                             q_ready,
  input  lrmg_pkg::entry_t                 q_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [lrmg_pkg::SAMPLE_W-1:0]    out_sample,
  output logic                             out_last
);

  localparam int SW = lrmg_pkg::SAMPLE_W;
  localparam int PW = lrmg_pkg::PHASE_W;

  // Sequencer state.
  logic [SW-1:0] prev_r, prev_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic          active_r, active_nxt;

  logic          en, issue, pop;
  logic [PW-1:0] phase_sum, phase_sub;
  logic          issue_last;

  // Pipeline registers.
  logic                 s1_v_r, s1_last_r;
  logic signed [25:0]   s1_prod_r;
  logic [SW-1:0]        s1_prev_r;
  logic                 s2_v_r, s2_last_r;
  logic signed [26:0]   s2_prod_r;
  logic                 out_valid_r, out_last_r;
  logic [SW-1:0]        out_data_r;

  logic signed [16:0]   diff;
  logic signed [8:0]    frac_s;
  logic signed [25:0]   s1_prod_nxt;
  logic signed [17:0]   s1_shift, interp18;
  logic signed [16:0]   interp;
  logic signed [9:0]    gain_s;
  logic signed [26:0]   s2_prod_nxt;
  logic signed [18:0]   scaled;
  logic [SW-1:0]        clamped;

  // The whole pipeline moves when the output register is free or taken.
  assign en      = !out_valid_r || out_ready;
  assign issue   = active_r && en;
  assign q_ready = !active_r;
  assign pop     = !active_r && q_valid;

  assign phase_sum  = phase_r + PW'(cfg.step);
  assign issue_last = (phase_sum >= lrmg_pkg::PHASE_ONE);
  assign phase_sub  = (phase_r >= lrmg_pkg::PHASE_ONE) ?
                      phase_r - lrmg_pkg::PHASE_ONE : phase_r;

  // Item intake and output issue.
  always_comb begin
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    phase_nxt  = phase_r;
    active_nxt = active_r;
    if (issue) begin
      phase_nxt  = phase_sum;
      active_nxt = !issue_last;
    end else if (pop) begin
      unique case (q_data.kind)
        lrmg_pkg::KIND_FIRST: begin
          prev_nxt = q_data.sample;
        end
        lrmg_pkg::KIND_SECOND: begin
          cur_nxt    = q_data.sample;
          phase_nxt  = '0;
          active_nxt = 1'b1;
        end
        lrmg_pkg::KIND_LATER: begin
          prev_nxt   = cur_r;
          cur_nxt    = q_data.sample;
          phase_nxt  = phase_sub;
          active_nxt = (phase_sub < lrmg_pkg::PHASE_ONE);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      cur_r    <= '0;
      phase_r  <= '0;
      active_r <= 1'b0;
    end else begin
      prev_r   <= prev_nxt;
      cur_r    <= cur_nxt;
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
    end
  end

  // Stage 1: difference times the 8-bit phase fraction.
  assign diff        = {cur_r[SW-1], cur_r} - {prev_r[SW-1], prev_r};
  assign frac_s      = {1'b0, phase_r[15:8]};
  assign s1_prod_nxt = diff * frac_s;

  // Stage 2: interpolated sample times the gain. Taking the upper bits of a
  // signed product floors the division by 256.
  assign s1_shift    = s1_prod_r[25:8];
  assign interp18    = {{2{s1_prev_r[SW-1]}}, s1_prev_r} + s1_shift;
  assign interp      = interp18[16:0];
  assign gain_s      = {1'b0, cfg.gain};
  assign s2_prod_nxt = interp * gain_s;

  // Stage 3: floor by 256 and clamp to 16 bits.
  assign scaled = s2_prod_r[26:8];
  always_comb begin
    if (scaled > 19'(lrmg_pkg::SAMPLE_MAX)) begin
      clamped = SW'(lrmg_pkg::SAMPLE_MAX);
    end else if (scaled < 19'(lrmg_pkg::SAMPLE_MIN)) begin
      clamped = SW'(lrmg_pkg::SAMPLE_MIN);
    end else begin
      clamped = scaled[SW-1:0];
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r  <= s1_prod_nxt;
      s1_prev_r  <= prev_r;
      s1_last_r  <= issue_last;
      s2_prod_r  <= s2_prod_nxt;
      s2_last_r  <= s1_last_r;
      out_data_r <= clamped;
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_data_r;
  assign out_last   = out_last_r;

  a_active_phase: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (phase_r < lrmg_pkg::PHASE_ONE))
    else $error("sequencer active with phase at or above one");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && issue_last) |=> !active_r)
    else $error("sequencer still active after the last output of an item");

  a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s2_v_r) |=> out_valid_r)
    else $error("stage 2 result lost on the way to the output register");

endmodule

`default_nettype wire

// ===== src/lrmg_cfg.sv =====
// Configuration registers on an APB-style port, plus the effective step and
// the mixer gain derived from them. Uses lrmg_pkg.
`default_nettype none

module lrmg_cfg (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [lrmg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire  [lrmg_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lrmg_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output lrmg_pkg::cfg_t                     cfg
);

  localparam int SW = lrmg_pkg::STEP_W;
  localparam int GW = lrmg_pkg::GAIN_W;
  localparam int PW = lrmg_pkg::PROD_W;

  logic [SW-1:0] step_reg_r;
  logic [7:0]    master_r, source_r;
  logic [SW-1:0] step_eff_r, step_eff_nxt;
  logic [PW-1:0] lvl_prod_r, lvl_prod_nxt;
  logic [GW-1:0] gain_r, gain_nxt;

  logic                              wr;
  logic [lrmg_pkg::REG_IDX_W-1:0]    idx;
  logic [17:0]                       recip_prod;
  logic [7:0]                        q_est;
  logic [15:0]                       rem;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_reg_r <= lrmg_pkg::STEP_RESET;
      master_r   <= lrmg_pkg::VOLUME_RESET;
      source_r   <= lrmg_pkg::VOLUME_RESET;
    end else if (wr) begin
      case (idx)
        lrmg_pkg::REG_PHASE_STEP:    step_reg_r <= pwdata[SW-1:0];
        lrmg_pkg::REG_MASTER_VOLUME: master_r   <= pwdata[7:0];
        lrmg_pkg::REG_SOURCE_VOLUME: source_r   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (idx)
      lrmg_pkg::REG_PHASE_STEP:    prdata = 32'(step_reg_r);
      lrmg_pkg::REG_MASTER_VOLUME: prdata = 32'(master_r);
      lrmg_pkg::REG_SOURCE_VOLUME: prdata = 32'(source_r);
      default:                     prdata = '0;
    endcase
  end

  // Effective step: zero and small values saturate to the minimum.
  assign step_eff_nxt = (step_reg_r < lrmg_pkg::STEP_MIN) ? lrmg_pkg::STEP_MIN : step_reg_r;

  // Level product, registered before the gain division.
  assign lvl_prod_nxt = {4'd0, lrmg_pkg::level_of(master_r)} *
                        {4'd0, lrmg_pkg::level_of(source_r)};

  // Gain = product * 256 / 225 by reciprocal estimate and one correction.
  assign recip_prod = {10'd0, lvl_prod_r} * 18'(lrmg_pkg::GAIN_RECIP);
  assign q_est      = recip_prod[17:lrmg_pkg::GAIN_SHIFT];
  assign rem        = {lvl_prod_r, 8'd0} - ({8'd0, q_est} * 16'(lrmg_pkg::GAIN_DIV));
  assign gain_nxt   = (rem >= 16'(lrmg_pkg::GAIN_DIV)) ? GW'(q_est) + 1'b1 : GW'(q_est);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_eff_r <= lrmg_pkg::STEP_RESET;
      lvl_prod_r <= PW'(lrmg_pkg::LEVEL_PROD_RESET);
      gain_r     <= GW'(lrmg_pkg::GAIN_RESET);
    end else begin
      step_eff_r <= step_eff_nxt;
      lvl_prod_r <= lvl_prod_nxt;
      gain_r     <= gain_nxt;
    end
  end

  assign cfg.step = step_eff_r;
  assign cfg.gain = gain_r;

endmodule

`default_nettype wire

// ===== sim/tb_linear_resampler_with_mixer_gain.sv =====
// Testbench for linear_resampler_with_mixer_gain: streams source samples, keeps
// its own interpolation and gain model, and checks every mixed output and tlast.
// Depends on lrmg_pkg and the linear_resampler_with_mixer_gain RTL.

module tb_linear_resampler_with_mixer_gain;

  localparam int SETTLE_CYCLES = 24;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 100;

  // Register index with no register behind it; writes there are dropped.
  localparam logic [lrmg_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] mixed;
    logic        last;
  } mix_result_t;

  // Clock, reset and block ports.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [15:0]                     in_tdata    = '0;  // [15:0] source_sample
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [15:0]                     out_tdata;         // [15:0] mixed_sample
  logic                            out_tlast;
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [lrmg_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [lrmg_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [lrmg_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // Model state and register copies.
  logic signed [15:0]           hist_prev   = '0;
  logic signed [15:0]           hist_cur    = '0;
  logic [lrmg_pkg::PHASE_W-1:0] phase_acc   = '0;
  int                           primed_cnt  = 0;
  logic [19:0]                  step_reg    = 20'd65536;
  logic [7:0]                   master_vol  = 8'd204;
  logic [7:0]                   source_vol  = 8'd204;

  mix_result_t pending_mix[$];
  mix_result_t head_mix;

  // Run bookkeeping.
  int  fail_cnt      = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  settings_done = 0;
  int  idle_cycles   = 0;
  int  burst_left    = 0;
  bit  tx_steady     = 1'b0;
  bit  rx_always     = 1'b0;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  stall_bit = '0;

  linear_resampler_with_mixer_gain u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver walks a 16-bit stall pattern that is redrawn each time the bit index wraps.
  always @(posedge clk) begin
    out_tready <= rx_always ? 1'b1 : stall_pat[stall_bit];
    stall_bit  <= stall_bit + 4'd1;
    if (stall_bit == 4'd15) begin
      case ($urandom_range(0, 3))
        0:       stall_pat <= 16'hFFFF;
        1:       stall_pat <= 16'($urandom & $urandom);
        default: stall_pat <= 16'($urandom);
      endcase
    end
  end

  // Compare each accepted output item with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_mix.size() == 0) begin
        $display("%0t: output item with none expected: expected none, actual %0d last %0b",
                 $time, $signed(out_tdata), out_tlast);
        fail_cnt++;
      end else begin
        head_mix = pending_mix.pop_front();
        if (out_tdata !== head_mix.mixed) begin
          $display("%0t: mixed_sample mismatch: expected %0d, actual %0d",
                   $time, $signed(head_mix.mixed), $signed(out_tdata));
          fail_cnt++;
        end
        if (out_tlast !== head_mix.last) begin
          $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                   $time, head_mix.last, out_tlast);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending_mix.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Work out the outputs that one source sample causes and queue them.
  task automatic predict_mixed(input logic signed [15:0] smp);
    int lvl_m, lvl_s, gain, frac, diff, interp, scaled, n;
    logic [lrmg_pkg::PHASE_W-1:0] step_eff, nxt;
    mix_result_t r;
    if (primed_cnt == 0) begin
      hist_prev  = smp;
      primed_cnt = 1;
      return;
    end
    if (primed_cnt == 1) begin
      hist_cur   = smp;
      phase_acc  = '0;
      primed_cnt = 2;
    end else begin
      hist_prev = hist_cur;
      hist_cur  = smp;
      if (phase_acc >= lrmg_pkg::PHASE_ONE) phase_acc = phase_acc - lrmg_pkg::PHASE_ONE;
    end
    // A zero volume byte stands for level 12; otherwise the upper nibble.
    lvl_m    = (master_vol == 8'd0) ? 12 : int'(master_vol[7:4]);
    lvl_s    = (source_vol == 8'd0) ? 12 : int'(source_vol[7:4]);
    gain     = lvl_m * lvl_s * 256 / 225;
    step_eff = (step_reg < 20'd1024) ? 21'd1024 : {1'b0, step_reg};
    n = 0;
    while (phase_acc < lrmg_pkg::PHASE_ONE && n < 64) begin
      frac   = int'(phase_acc[15:8]);
      diff   = int'(hist_cur) - int'(hist_prev);
      interp = int'(hist_prev) + ((diff * frac) >>> 8);
      scaled = (interp * gain) >>> 8;
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      nxt     = phase_acc + step_eff;
      r.mixed = scaled[15:0];
      r.last  = (nxt >= lrmg_pkg::PHASE_ONE) || (n == 63);
      pending_mix.push_back(r);
      phase_acc = nxt;
      n++;
    end
  endtask

  // Send one source sample; valid stays high across a burst.
  task automatic send_sample(input logic [15:0] smp);
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_mixed(smp);
    if (!tx_steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        burst_left = $urandom_range(0, 24);
      end
    end
  endtask

  // Stop sending, wait for every expected output, then let the block go idle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Read one register and compare it, then leave the port idle.
  task automatic cfg_read_check(input logic [lrmg_pkg::REG_IDX_W-1:0] idx,
                                input logic [31:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $display("%0t: register %0d readback mismatch: expected 0x%0h, actual 0x%0h",
               $time, idx, want, cfg_prdata);
      fail_cnt++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write one register, update the model copy and read it back unless the index is unused.
  task automatic cfg_write_check(input logic [lrmg_pkg::REG_IDX_W-1:0] idx,
                                 input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      lrmg_pkg::REG_PHASE_STEP:    step_reg   = val[19:0];
      lrmg_pkg::REG_MASTER_VOLUME: master_vol = val[7:0];
      lrmg_pkg::REG_SOURCE_VOLUME: source_vol = val[7:0];
      default: ;
    endcase
    if (idx == REG_UNUSED) begin
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      @(posedge clk);
    end else begin
      cfg_read_check(idx, val);
    end
  endtask

  // Change all three registers while the block is idle.
  task automatic apply_settings(input logic [19:0] stp, input logic [7:0] mst,
                                input logic [7:0] src);
    drain_results();
    cfg_write_check(lrmg_pkg::REG_PHASE_STEP, {12'd0, stp});
    cfg_write_check(lrmg_pkg::REG_MASTER_VOLUME, {24'd0, mst});
    cfg_write_check(lrmg_pkg::REG_SOURCE_VOLUME, {24'd0, src});
    settings_done++;
    // Wait for the derived step and gain to follow the writes.
    repeat (4) @(posedge clk);
  endtask

  // Priming with the reset settings: first sample gives nothing, second starts output.
  task automatic test_priming();
    cfg_read_check(lrmg_pkg::REG_PHASE_STEP, 32'd65536);
    cfg_read_check(lrmg_pkg::REG_MASTER_VOLUME, 32'd204);
    cfg_read_check(lrmg_pkg::REG_SOURCE_VOLUME, 32'd204);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
  endtask

  // Smallest step (zero and below the floor) and largest step with absorbed samples.
  task automatic test_step_extremes();
    apply_settings(20'd0, 8'hFF, 8'hFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    apply_settings(20'd1023, 8'hCC, 8'hCC);
    send_sample(16'h1234);
    apply_settings(20'hFFFFF, 8'hFF, 8'hFF);
    send_sample(16'hEDCB);
    send_sample(16'h4000);
    send_sample(16'hC000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    apply_settings(20'h18000, 8'hFF, 8'hFF);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
  endtask

  // Gain corners: default levels, zero level, smallest nonzero level.
  task automatic test_gain_settings();
    apply_settings(20'h08000, 8'h00, 8'h00);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    apply_settings(20'h10000, 8'h0F, 8'hFF);
    send_sample(16'h7FFF);
    apply_settings(20'h10000, 8'h10, 8'hF0);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    // A write to the unused index must leave the gain alone.
    drain_results();
    cfg_write_check(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(16'h8001);
  endtask

  // Random settings per phase; samples are mostly a bounded walk with extremes mixed in.
  task automatic test_random_stream();
    logic [19:0] stp;
    logic [7:0]  mst, src;
    logic [15:0] smp;
    int          delta;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       stp = 20'($urandom_range(0, 1023));
        1:       stp = 20'($urandom_range(1024, 8191));
        2:       stp = 20'($urandom_range(8192, 65535));
        3:       stp = 20'd65536;
        4:       stp = 20'($urandom_range(65537, 262143));
        default: stp = 20'($urandom);
      endcase
      mst = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
      src = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
      apply_settings(stp, mst, src);
      // One phase runs with no idling on either side.
      tx_steady = (ph == 2);
      rx_always = (ph == 2);
      smp = 16'($urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 9))
          0:       smp = 16'($urandom);
          1:       smp = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
          default: begin
            delta = $urandom_range(0, 4096) - 2048;
            smp   = 16'(int'($signed(smp)) + delta);
          end
        endcase
        send_sample(smp);
      end
      tx_steady = 1'b0;
      rx_always = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_priming();
    test_step_extremes();
    test_gain_settings();
    test_random_stream();
    drain_results();
    $display("Sent %0d source items under %0d register settings; checked %0d output items.",
             items_sent, settings_done, results_seen);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
